[design/b2nw_pkg.sv]
package b2nw_pkg;

   localparam int unsigned ROUNDS          = 12;
   localparam int unsigned STEPS_PER_ROUND = 8;
   localparam int unsigned STAGES          = ROUNDS * STEPS_PER_ROUND;
   localparam int unsigned SIGMA_ROWS      = 10;
   localparam int unsigned CSR_INDEX_W     = 3;

   typedef logic [63:0]       word_type;
   typedef logic [15:0][63:0] vec_type;
   typedef logic [3:0][63:0]  lane_type;

   // One pipeline step: column or diagonal pass, first or second half of
   // the mix, and whether this step performs the a/d update or the c/b update.
   typedef struct packed {
      logic diag;
      logic second;
      logic sub;
   } step_type;

   localparam logic [CSR_INDEX_W-1:0] REG_ROOT_0    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ROOT_1    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROOT_2    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ROOT_3    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD = 3'd4;

   localparam word_type PARAM_WORD      = 64'h0000_0000_0101_0008;
   localparam word_type MSG_BYTES       = 64'd40;
   localparam word_type FINAL_FLAG      = 64'hffff_ffff_ffff_ffff;
   localparam word_type THRESHOLD_RESET = 64'hffff_fff8_0000_0000;

   localparam word_type IV [0:7] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
      64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam word_type H0 = IV[0] ^ PARAM_WORD;

   localparam logic [3:0] SIGMA [0:9][0:15] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
      '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
        4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
      '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
        4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
      '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
        4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
      '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
        4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
      '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
        4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
      '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
        4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
      '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
        4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
      '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
        4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
   };

   // Working vector at the start of the single final-block compression.
   function automatic vec_type init_vector();
      vec_type v;
      v[0] = H0;
      for (int i = 1; i < 8; i++) begin
         v[i] = IV[i];
      end
      for (int i = 0; i < 8; i++) begin
         v[8 + i] = IV[i];
      end
      v[12] = v[12] ^ MSG_BYTES;
      v[14] = v[14] ^ FINAL_FLAG;
      return v;
   endfunction

   // Message word index for one lane of one half-mix.
   // The last two rounds reuse the first two permutation rows.
   function automatic logic [3:0] msg_index(int unsigned rnd, logic diag, logic second,
                                            int unsigned lane);
      int unsigned pos;
      int unsigned row;
      pos = (diag ? 8 : 0) + 2 * lane + (second ? 1 : 0);
      row = (rnd >= SIGMA_ROWS) ? rnd - SIGMA_ROWS : rnd;
      return SIGMA[row][pos];
   endfunction

   // Message block: nonce, four root words, then zero padding.
   function automatic word_type msg_word(logic [3:0] idx, word_type nonce, lane_type root);
      word_type w;
      case (idx)
         4'd0:    w = nonce;
         4'd1:    w = root[0];
         4'd2:    w = root[1];
         4'd3:    w = root[2];
         4'd4:    w = root[3];
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

[design/blake2b_nonce_work_check_core.sv]
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_candidate
// rsp       out        rsp_valid/rsp_stall   rsp_candidate_out, rsp_digest_word, rsp_passes
// csr       in         csr_write_enable      csr_index, csr_write_data
//
// One request per cycle sustained while no response is held under rsp_stall; each request
// passes 96 quarter-mix stages, four lanes each, then the finalise and compare register.
// Reset is synchronous; it clears the stage valid bits and root words, presets the threshold.
// A stalled response freezes the whole pipeline at once, so nothing is lost or
// repeated; req_stall rises only while a response waits under rsp_stall.
module blake2b_nonce_work_check_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [63:0]                         req_candidate,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [63:0]                         rsp_candidate_out,
   output logic [63:0]                         rsp_digest_word,
   output logic                                rsp_passes,
   input  logic                                csr_write_enable,
   input  logic [b2nw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]                         csr_write_data
);

   // Configuration registers.
   b2nw_pkg::lane_type root_ff;
   b2nw_pkg::word_type threshold_ff;

   // Pipeline taps: index 0 is the request side, index STAGES the last stage.
   logic               pipe_valid [0:b2nw_pkg::STAGES];
   b2nw_pkg::word_type pipe_nonce [0:b2nw_pkg::STAGES];
   b2nw_pkg::vec_type  pipe_v     [0:b2nw_pkg::STAGES];

   logic               advance;
   logic               rsp_valid_ff;
   b2nw_pkg::word_type rsp_candidate_ff;
   b2nw_pkg::word_type rsp_digest_ff;
   logic               rsp_passes_ff;
   b2nw_pkg::word_type digest_in;
   logic               passes_in;

   // The entire pipeline moves together unless the response register is held.
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // Configuration writes; indexes past the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= '0;
         threshold_ff <= b2nw_pkg::THRESHOLD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            b2nw_pkg::REG_ROOT_0:    root_ff[0]   <= csr_write_data;
            b2nw_pkg::REG_ROOT_1:    root_ff[1]   <= csr_write_data;
            b2nw_pkg::REG_ROOT_2:    root_ff[2]   <= csr_write_data;
            b2nw_pkg::REG_ROOT_3:    root_ff[3]   <= csr_write_data;
            b2nw_pkg::REG_THRESHOLD: threshold_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign pipe_valid[0] = req_valid;
   assign pipe_nonce[0] = req_candidate;
   assign pipe_v[0]     = b2nw_pkg::init_vector();

   // Eight stages a round: column pass then diagonal pass, each as two
   // half-mixes of two steps (a/d update, then c/b update).
   for (genvar s = 0; s < b2nw_pkg::STAGES; s++) begin : g_stage
      localparam int unsigned RND   = s / b2nw_pkg::STEPS_PER_ROUND;
      localparam int unsigned PHASE = s % b2nw_pkg::STEPS_PER_ROUND;
      localparam bit          DIAG   = ((PHASE / 4) % 2) == 1;
      localparam bit          SECOND = ((PHASE / 2) % 2) == 1;
      localparam bit          SUB    = (PHASE % 2) == 1;

      b2nw_pkg::step_type step;
      b2nw_pkg::lane_type x;

      assign step.diag   = DIAG;
      assign step.second = SECOND;
      assign step.sub    = SUB;

      // Message words for this step; the nonce comes along with its own item.
      always_comb begin
         for (int l = 0; l < 4; l++) begin
            x[l] = b2nw_pkg::msg_word(b2nw_pkg::msg_index(RND, DIAG, SECOND, l),
                                      pipe_nonce[s], root_ff);
         end
      end

      b2nw_step u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .step      (step),
         .valid_in  (pipe_valid[s]),
         .nonce_in  (pipe_nonce[s]),
         .v_in      (pipe_v[s]),
         .x_in      (x),
         .valid_out (pipe_valid[s + 1]),
         .nonce_out (pipe_nonce[s + 1]),
         .v_out     (pipe_v[s + 1])
      );
   end

   // Finalise: only the first output word is needed for an 8-byte digest.
   assign digest_in = b2nw_pkg::H0 ^ pipe_v[b2nw_pkg::STAGES][0]
                      ^ pipe_v[b2nw_pkg::STAGES][8];
   assign passes_in = (digest_in >= threshold_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pipe_valid[b2nw_pkg::STAGES];
      end
   end

   // Hold the response while stalled.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_candidate_ff <= pipe_nonce[b2nw_pkg::STAGES];
         rsp_digest_ff    <= digest_in;
         rsp_passes_ff    <= passes_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_candidate_out = rsp_candidate_ff;
   assign rsp_digest_word   = rsp_digest_ff;
   assign rsp_passes        = rsp_passes_ff;

   a_req_enters_stage: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> pipe_valid[1] && pipe_nonce[1] == $past(req_candidate))
      else $error("accepted request did not enter the first stage");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(pipe_nonce[1]) && $stable(pipe_valid[1]))
      else $error("first stage moved during a stall");

   a_last_stage_to_rsp: assert property (@(posedge clock) disable iff (reset)
      pipe_valid[b2nw_pkg::STAGES] && advance
      |=> rsp_valid && rsp_candidate_out == $past(pipe_nonce[b2nw_pkg::STAGES]))
      else $error("last stage not handed to the response register");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid && !pipe_valid[1])
      else $error("reset left a valid item in the pipeline");

endmodule

[design/b2nw_step.sv]
module b2nw_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  b2nw_pkg::step_type step,
   input  logic               valid_in,
   input  b2nw_pkg::word_type nonce_in,
   input  b2nw_pkg::vec_type  v_in,
   input  b2nw_pkg::lane_type x_in,
   output logic               valid_out,
   output b2nw_pkg::word_type nonce_out,
   output b2nw_pkg::vec_type  v_out
);

   logic               valid_ff;
   b2nw_pkg::word_type nonce_ff;
   b2nw_pkg::vec_type  v_ff;
   b2nw_pkg::vec_type  v_in_next;

   // Four independent lanes; each touches its own a, b, c, d words.
   always_comb begin
      logic [1:0]         l2;
      logic [1:0]         lb;
      logic [1:0]         lc;
      logic [1:0]         ld;
      logic [3:0]         ia;
      logic [3:0]         ib;
      logic [3:0]         ic;
      logic [3:0]         id;
      b2nw_pkg::word_type a_new;
      b2nw_pkg::word_type c_new;
      b2nw_pkg::word_type dx;
      b2nw_pkg::word_type bx;
      v_in_next = v_in;
      for (int l = 0; l < 4; l++) begin
         l2    = 2'(l);
         lb    = l2 + {1'b0, step.diag};
         lc    = l2 + {step.diag, 1'b0};
         ld    = l2 + {2{step.diag}};
         ia    = {2'b00, l2};
         ib    = {2'b01, lb};
         ic    = {2'b10, lc};
         id    = {2'b11, ld};
         a_new = v_in[ia] + v_in[ib] + x_in[l2];
         dx    = v_in[id] ^ a_new;
         c_new = v_in[ic] + v_in[id];
         bx    = v_in[ib] ^ c_new;
         if (!step.sub) begin
            v_in_next[ia] = a_new;
            v_in_next[id] = step.second ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
         end else begin
            v_in_next[ic] = c_new;
            v_in_next[ib] = step.second ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload while stalled.
   always_ff @(posedge clock) begin
      if (advance) begin
         nonce_ff <= nonce_in;
         v_ff     <= v_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign nonce_out = nonce_ff;
   assign v_out     = v_ff;

endmodule

[bench/blake2b_nonce_work_check_core_test.sv]
`timescale 1ns / 100ps

module blake2b_nonce_work_check_core_test;

   // Request-to-response depth of the hash pipeline, used to watch for stray responses.
   localparam int unsigned PIPE_LATENCY = 97;
   localparam int unsigned TIMEOUT_NS   = 400000;
   localparam int unsigned BATCHES      = 4;
   localparam int unsigned BATCH_ITEMS  = 42;

   typedef logic [b2nw_pkg::CSR_INDEX_W-1:0] csr_index_type;

   // Register indexes past the last register: writes to them must be dropped.
   localparam logic [b2nw_pkg::CSR_INDEX_W-1:0] REG_UNUSED_5 = 3'd5;
   localparam logic [b2nw_pkg::CSR_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
   localparam logic [b2nw_pkg::CSR_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;

   localparam logic [63:0] ALL_ONES           = 64'hffff_ffff_ffff_ffff;
   localparam logic [63:0] THRESHOLD_AT_RESET = 64'hffff_fff8_0000_0000;

   // BLAKE2b parameter block word 0: digest length 8, no key, fanout and depth 1.
   localparam logic [63:0] B2_PARAM_WORD = 64'h0000_0000_0101_0008;
   localparam logic [63:0] B2_MSG_LEN    = 64'd40;

   localparam logic [63:0] B2_IV [0:7] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
      64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   // Message word order for each of the twelve rounds.
   localparam int unsigned MSG_ORDER [0:11][0:15] = '{
      '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
      '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
      '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
      '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
      '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
      '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
      '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
      '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
      '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
      '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0},
      '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
      '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3}
   };

   // Working-vector lanes of the eight mixes in a round: four columns, four diagonals.
   localparam int unsigned LANE_A [0:7] = '{0, 1, 2, 3, 0, 1, 2, 3};
   localparam int unsigned LANE_B [0:7] = '{4, 5, 6, 7, 5, 6, 7, 4};
   localparam int unsigned LANE_C [0:7] = '{8, 9, 10, 11, 10, 11, 8, 9};
   localparam int unsigned LANE_D [0:7] = '{12, 13, 14, 15, 15, 12, 13, 14};

   typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_type;

   // One line of the directed table: a request, or a register write done while idle.
   // Where pass_known is set, the pass flag is typed in and checked as well.
   typedef struct packed {
      row_kind_type                       kind;
      logic [b2nw_pkg::CSR_INDEX_W-1:0]   index;
      logic [63:0]                        value;
      logic                               pass_known;
      logic                               pass_typed;
   } stim_row_type;

   typedef struct {
      logic [63:0] candidate;
      logic [63:0] digest;
      logic        passes;
      logic        pass_known;
      logic        pass_typed;
   } awaited_type;

   localparam int unsigned DIRECTED_ROWS = 31;

   localparam stim_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      // reset configuration: zero root, threshold at its reset value
      '{ROW_REQUEST, '0, 64'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, ALL_ONES, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'h1, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'h8000_0000_0000_0000, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'h5555_5555_5555_5555, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0},
      // zero threshold: every candidate passes
      '{ROW_WRITE, b2nw_pkg::REG_THRESHOLD, 64'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'h0, 1'b1, 1'b1},
      '{ROW_REQUEST, '0, ALL_ONES, 1'b1, 1'b1},
      '{ROW_REQUEST, '0, 64'h0123_4567_89ab_cdef, 1'b1, 1'b1},
      // all-ones threshold: only an all-ones digest would pass
      '{ROW_WRITE, b2nw_pkg::REG_THRESHOLD, ALL_ONES, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, ALL_ONES, 1'b0, 1'b0},
      // extreme root words
      '{ROW_WRITE, b2nw_pkg::REG_ROOT_0, ALL_ONES, 1'b0, 1'b0},
      '{ROW_WRITE, b2nw_pkg::REG_ROOT_1, 64'h5555_5555_5555_5555, 1'b0, 1'b0},
      '{ROW_WRITE, b2nw_pkg::REG_ROOT_2, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0},
      '{ROW_WRITE, b2nw_pkg::REG_ROOT_3, ALL_ONES, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, ALL_ONES, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'h0000_0000_ffff_ffff, 1'b0, 1'b0},
      // writes past the last register are dropped; a zero landing on the
      // threshold or a root word would show up in the next results
      '{ROW_WRITE, REG_UNUSED_5, 64'h0, 1'b0, 1'b0},
      '{ROW_WRITE, REG_UNUSED_6, 64'h0, 1'b0, 1'b0},
      '{ROW_WRITE, REG_UNUSED_7, 64'h0, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'hfedc_ba98_7654_3210, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'h0, 1'b0, 1'b0},
      // back to the reset threshold, root left at its extremes
      '{ROW_WRITE, b2nw_pkg::REG_THRESHOLD, THRESHOLD_AT_RESET, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'h0000_0001_0000_0000, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'hffff_ffff_0000_0000, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'h7fff_ffff_ffff_ffff, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'hffff_ffff_ffff_fffe, 1'b0, 1'b0},
      '{ROW_REQUEST, '0, 64'h8000_0000_0000_0001, 1'b0, 1'b0}
   };

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [63:0]                      req_candidate = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [63:0]                      rsp_candidate_out;
   logic [63:0]                      rsp_digest_word;
   logic                             rsp_passes;
   logic                             csr_write_enable = 1'b0;
   logic [b2nw_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]                      csr_write_data = '0;

   // Bench copy of the configuration, updated on every register write.
   logic [63:0] root_word [0:3];
   logic [63:0] pass_threshold;

   awaited_type awaited_results [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned requests_sent = 0;
   int unsigned responses_checked = 0;
   int unsigned passes_seen = 0;
   int unsigned register_writes = 0;
   int unsigned errors = 0;

   blake2b_nonce_work_check_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_candidate     (req_candidate),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_candidate_out (rsp_candidate_out),
      .rsp_digest_word   (rsp_digest_word),
      .rsp_passes        (rsp_passes),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic logic [63:0] rotr64(input logic [63:0] x, input int unsigned n);
      return (x >> n) | (x << (64 - n));
   endfunction

   // Full G function; returns {d, c, b, a}.
   function automatic logic [3:0][63:0] g_mix(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] c, input logic [63:0] d,
                                              input logic [63:0] x, input logic [63:0] y);
      a = a + b + x;
      d = rotr64(d ^ a, 32);
      c = c + d;
      b = rotr64(b ^ c, 24);
      a = a + b + y;
      d = rotr64(d ^ a, 16);
      c = c + d;
      b = rotr64(b ^ c, 63);
      return {d, c, b, a};
   endfunction

   // Digest word of nonce || root under the current bench configuration:
   // one final-block compression, byte counter 40, 8-byte output.
   function automatic logic [63:0] pow_digest(input logic [63:0] nonce);
      logic [63:0]      msg [0:15];
      logic [63:0]      v [0:15];
      logic [3:0][63:0] quad;
      logic [63:0]      h0;
      int unsigned      s0;
      int unsigned      s1;
      h0 = B2_IV[0] ^ B2_PARAM_WORD;
      for (int i = 0; i < 16; i++) begin
         msg[i] = '0;
      end
      msg[0] = nonce;
      for (int i = 0; i < 4; i++) begin
         msg[1 + i] = root_word[i];
      end
      for (int i = 0; i < 8; i++) begin
         v[i]     = B2_IV[i];
         v[8 + i] = B2_IV[i];
      end
      v[0]  = h0;
      v[12] = v[12] ^ B2_MSG_LEN;
      v[14] = ~v[14];
      for (int r = 0; r < 12; r++) begin
         for (int g = 0; g < 8; g++) begin
            s0   = MSG_ORDER[r][2 * g];
            s1   = MSG_ORDER[r][2 * g + 1];
            quad = g_mix(v[LANE_A[g]], v[LANE_B[g]], v[LANE_C[g]], v[LANE_D[g]],
                         msg[s0], msg[s1]);
            v[LANE_A[g]] = quad[0];
            v[LANE_B[g]] = quad[1];
            v[LANE_C[g]] = quad[2];
            v[LANE_D[g]] = quad[3];
         end
      end
      return h0 ^ v[0] ^ v[8];
   endfunction

   // Mirror a register write into the bench configuration; drop unused indexes.
   function automatic void track_register(input logic [b2nw_pkg::CSR_INDEX_W-1:0] index,
                                          input logic [63:0] value);
      case (index)
         b2nw_pkg::REG_ROOT_0:    root_word[0] = value;
         b2nw_pkg::REG_ROOT_1:    root_word[1] = value;
         b2nw_pkg::REG_ROOT_2:    root_word[2] = value;
         b2nw_pkg::REG_ROOT_3:    root_word[3] = value;
         b2nw_pkg::REG_THRESHOLD: pass_threshold = value;
         default: ;
      endcase
   endfunction

   // Drop valid and wait until every awaited response has come back.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write one register once the block is idle. The enable is a one-cycle strobe,
   // lowered before the task returns, so back-to-back writes never assign it twice in one step.
   task automatic write_register(input logic [b2nw_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [63:0] value);
      drain_pipeline();
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      track_register(index, value);
      register_writes++;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one request, with random idle cycles ahead of it, and hold it until
   // the block takes it. On acceptance, queue the predicted response.
   task automatic send_request(input logic [63:0] candidate, input logic pass_known,
                               input logic pass_typed);
      awaited_type item;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_candidate <= candidate;
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         @(posedge clock);
      end
      item.candidate  = candidate;
      item.digest     = pow_digest(candidate);
      item.passes     = (item.digest >= pass_threshold);
      item.pass_known = pass_known;
      item.pass_typed = pass_typed;
      awaited_results.push_back(item);
      requests_sent++;
   endtask

   // Candidates lean towards the edges: small values, near all ones, single
   // bits; the rest are uniform over 64 bits.
   function automatic logic [63:0] random_candidate();
      logic [63:0] value;
      case ($urandom_range(0, 7))
         0:       value = 64'($urandom_range(0, 255));
         1:       value = ALL_ONES - 64'($urandom_range(0, 255));
         2:       value = 64'h1 << $urandom_range(0, 63);
         default: value = {$urandom, $urandom};
      endcase
      return value;
   endfunction

   function automatic logic [63:0] random_root();
      logic [63:0] value;
      case ($urandom_range(0, 5))
         0:       value = '0;
         1:       value = ALL_ONES;
         default: value = {$urandom, $urandom};
      endcase
      return value;
   endfunction

   // Threshold mix keeps both pass and fail results coming, with the extremes
   // and the reset value visited now and then.
   function automatic logic [63:0] random_threshold();
      logic [63:0] value;
      case ($urandom_range(0, 7))
         0:       value = '0;
         1:       value = ALL_ONES;
         2:       value = THRESHOLD_AT_RESET;
         default: value = {$urandom, $urandom};
      endcase
      return value;
   endfunction

   // Response side: stall at random and check each accepted response against
   // the oldest awaited one, field by field.
   always @(posedge clock) begin
      awaited_type item;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: response with nothing outstanding: candidate %h digest %h",
                     $realtime, rsp_candidate_out, rsp_digest_word);
            errors++;
         end else begin
            item = awaited_results.pop_front();
            responses_checked++;
            if (rsp_candidate_out !== item.candidate) begin
               $display("%0t: candidate_out expected %h actual %h",
                        $realtime, item.candidate, rsp_candidate_out);
               errors++;
            end
            if (rsp_digest_word !== item.digest) begin
               $display("%0t: digest_word for %h expected %h actual %h",
                        $realtime, item.candidate, item.digest, rsp_digest_word);
               errors++;
            end
            if (rsp_passes !== item.passes) begin
               $display("%0t: passes for %h expected %b actual %b",
                        $realtime, item.candidate, item.passes, rsp_passes);
               errors++;
            end
            // Rows with the flag typed in are held to that value too.
            if (item.pass_known && rsp_passes !== item.pass_typed) begin
               $display("%0t: passes for %h (table) expected %b actual %b",
                        $realtime, item.candidate, item.pass_typed, rsp_passes);
               errors++;
            end
            if (rsp_passes === 1'b1) begin
               passes_seen++;
            end
         end
      end
   end

   initial begin
      // Reset leaves the root at zero and the threshold at its reset value.
      for (int i = 0; i < 4; i++) begin
         root_word[i] = '0;
      end
      pass_threshold = THRESHOLD_AT_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table, under light sender idling and heavy receiver stalls.
      send_idle_pct = 6;
      recv_idle_pct = 74;
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         if (DIRECTED[row].kind == ROW_WRITE) begin
            write_register(DIRECTED[row].index, DIRECTED[row].value);
         end else begin
            send_request(DIRECTED[row].value, DIRECTED[row].pass_known,
                         DIRECTED[row].pass_typed);
         end
      end

      // Random part: three idling regimes, each over several configurations.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 74;
            end
            1: begin
               send_idle_pct = 74;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int batch = 0; batch < BATCHES; batch++) begin
            write_register(b2nw_pkg::REG_ROOT_0, random_root());
            write_register(b2nw_pkg::REG_ROOT_1, random_root());
            write_register(b2nw_pkg::REG_ROOT_2, random_root());
            write_register(b2nw_pkg::REG_ROOT_3, random_root());
            write_register(b2nw_pkg::REG_THRESHOLD, random_threshold());
            // Now and then poke an unused index with random data.
            if ($urandom_range(0, 3) == 0) begin
               write_register(csr_index_type'($urandom_range(REG_UNUSED_5, REG_UNUSED_7)),
                              {$urandom, $urandom});
            end
            for (int k = 0; k < BATCH_ITEMS; k++) begin
               send_request(random_candidate(), 1'b0, 1'b0);
            end
         end
      end

      // Let everything drain, then watch a little longer for stray responses.
      drain_pipeline();
      repeat (PIPE_LATENCY + 10) @(posedge clock);

      $display("Covered %0d requests, %0d responses checked (%0d passing), %0d register writes.",
               requests_sent, responses_checked, passes_seen, register_writes);
      $display("Idling regimes: sender light / receiver heavy, the reverse, and none; %0d errors.",
               errors);
      if (errors == 0) begin
         $display("blake2b_nonce_work_check_core regression: pass");
      end else begin
         $display("blake2b_nonce_work_check_core regression: fail");
      end
      $finish;
   end

   // Hard stop in case the handshake locks up.
   initial begin
      #(TIMEOUT_NS);
      $display("%0t: timed out with %0d responses still awaited",
               $realtime, awaited_results.size());
      $display("blake2b_nonce_work_check_core regression: fail");
      $finish;
   end

endmodule
